/* rtl/hash_table_quadratic_probe_replace_top_defines.svh */
// Assertion macros shared by the hash table RTL.
// Assumes clk_i and rst_ni in the scope of every use.
`ifndef HASH_TABLE_QUADRATIC_PROBE_REPLACE_TOP_DEFINES_SVH
`define HASH_TABLE_QUADRATIC_PROBE_REPLACE_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HQPR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define HQPR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/hqpr_pkg.sv */
// Types and constants of the quadratic probe hash table.
// No dependencies.
`default_nettype none

package hqpr_pkg;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_PV    = 2'd1;
  localparam logic [1:0] KIND_CUT   = 2'd2;
  localparam logic [1:0] KIND_ALL   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_BOUND = 2'd2;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned FILL_W      = 7;
  localparam logic [FILL_W-1:0] FILL_RESET = 7'd75;
  localparam int unsigned FILL_SCALE  = 100;

  typedef struct packed {
    logic [1:0]        action;
    logic [KEY_W-1:0]  key;
    logic signed [15:0] score;
    logic [1:0]        node_kind;
    logic [15:0]       move_code;
    logic [11:0]       age;
    logic [11:0]       search_depth;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic              written;
    logic [1:0]        status;
    logic signed [15:0] score_out;
    logic [1:0]        kind_out;
    logic [15:0]       move_out;
    logic [11:0]       age_out;
    logic [11:0]       depth_out;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic signed [15:0] score;
    logic [1:0]        kind;
    logic [15:0]       move;
    logic [11:0]       age;
    logic [11:0]       depth;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/hqpr_ram.sv */
// Generic simple dual-port RAM with registered read data.
// No dependencies.
`default_nettype none

module hqpr_ram #(
  parameter int unsigned WIDTH = 122,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/hqpr_mod.sv */
// Home slot of a key: its low bits, registered, for a power-of-two table size.
// No dependencies.
`default_nettype none

module hqpr_mod #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] key_i,
  output logic                                  done_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      slot_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  logic [IW-1:0] slot_q, slot_d;
  logic          done_q, done_d;

  always_comb begin
    slot_d = slot_q;
    done_d = start_i;
    if (start_i) begin
      slot_d = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign done_o = done_q;
  assign slot_o = slot_q;

endmodule

`default_nettype wire

/* rtl/hash_table_quadratic_probe_replace_top.sv */
// Top level of the quadratic probe hash table: sequencer, probe and policy logic.
// Depends on hqpr_pkg, hqpr_mod, hqpr_ram and the defines header.
//
//   channel  signals                          direction
//   input    in_valid_i in_ready_o in_word_i  into block
//   result   out_valid_o out_ready_i out_word_o  out of block
//   config   cfg_we_i cfg_wdata_i             into block
//
// Lookup, update, insert: ST_IDLE takes the word, ST_HASH gets the home slot (low key
// bits, TABLE_ENTRIES a power of two), each probed slot passes ST_READ and ST_CHECK
// (registered RAM read); ST_DONE loads the output register. At most PROBE_LIMIT probes.
// Clear writes one slot per cycle, until all TABLE_ENTRIES slots are written.
// After reset the same sweep runs with in_ready_o low.
// A finished word waits in the output register; the next word is taken meanwhile.
`default_nettype none
`include "hash_table_quadratic_probe_replace_top_defines.svh"

module hash_table_quadratic_probe_replace_top #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned PROBE_LIMIT   = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire hqpr_pkg::in_word_t             in_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output hqpr_pkg::out_word_t                 out_word_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [hqpr_pkg::FILL_W-1:0]    cfg_wdata_i
);
  import hqpr_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KW = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned LW = CW + FILL_W + 1;
  localparam logic [IW:0] N_L = (IW+1)'(TABLE_ENTRIES);

  function automatic logic [IW-1:0] mod_add(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= N_L) begin
      s = s - N_L;
    end
    return s[IW-1:0];
  endfunction

  state_e          state_q, state_d;
  in_word_t        in_q, in_d;
  out_word_t       res_q, res_d;
  out_word_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [FILL_W-1:0] fill_q;
  logic [CW-1:0]   count_q, count_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   sq_q, sq_d;
  logic [IW-1:0]   dd_q, dd_d;
  logic [KW-1:0]   k_q, k_d;
  logic [IW-1:0]   clr_q, clr_d;
  logic            clr_resp_q, clr_resp_d;

  logic            mod_start;
  logic            mod_done;
  logic [IW-1:0]   mod_slot;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t          cur;
  entry_t          fresh;
  logic            at_limit;

  assign cur = entry_t'(ram_rdata);
  assign at_limit = (LW'(count_q) * LW'(FILL_SCALE)) >= (LW'(fill_q) * LW'(TABLE_ENTRIES));

  always_comb begin
    fresh = '0;
    if (in_q.node_kind != KIND_EMPTY) begin
      fresh.key   = in_q.key;
      fresh.score = in_q.score;
      fresh.kind  = in_q.node_kind;
      fresh.move  = in_q.move_code;
      fresh.age   = in_q.age;
      fresh.depth = in_q.search_depth;
    end
  end

  hqpr_mod #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (in_word_i.key[IW-1:0]),
    .done_o  (mod_done),
    .slot_o  (mod_slot)
  );

  hqpr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic hit, found, go, wr, allow;
    state_d       = state_q;
    in_d          = in_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    count_d       = count_q;
    idx_d         = idx_q;
    sq_d          = sq_q;
    dd_d          = dd_q;
    k_d           = k_q;
    clr_d         = clr_q;
    clr_resp_d    = clr_resp_q;
    mod_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = '0;
    in_ready_o    = 1'b0;
    hit           = 1'b0;
    found         = 1'b0;
    go            = 1'b0;
    wr            = 1'b0;
    allow         = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + IW'(1);
        if (clr_q == IW'(TABLE_ENTRIES - 1)) begin
          count_d = '0;
          res_d   = '0;
          state_d = clr_resp_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_d = in_word_i;
          if (in_word_i.action == ACT_CLEAR) begin
            clr_d      = '0;
            clr_resp_d = 1'b1;
            state_d    = ST_CLEAR;
          end else begin
            mod_start = 1'b1;
            state_d   = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          idx_d   = mod_slot;
          sq_d    = IW'(1);
          dd_d    = IW'(3);
          k_d     = KW'(1);
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        hit = (cur.kind == KIND_EMPTY) || (cur.key == in_q.key);
        if (hit) begin
          found = cur.kind != KIND_EMPTY;
          allow = (cur.kind == KIND_EMPTY) || (cur.age < in_q.age) ||
                  (in_q.node_kind == KIND_CUT && cur.kind == KIND_CUT &&
                   $signed(in_q.score) > $signed(cur.score)) ||
                  (in_q.node_kind == KIND_ALL && cur.kind != KIND_PV) ||
                  (in_q.node_kind == KIND_PV);
          go = (in_q.action == ACT_INSERT) || (in_q.action == ACT_UPDATE && allow);
          wr = go && (found || !at_limit);
          res_d.found   = found;
          res_d.written = wr;
          res_d.status  = (go && !wr) ? STAT_FULL : STAT_OK;
          if (wr) begin
            ram_we    = 1'b1;
            ram_wdata = fresh;
            if (in_q.node_kind == KIND_EMPTY && found) begin
              count_d = count_q - CW'(1);
            end else if (in_q.node_kind != KIND_EMPTY && !found) begin
              count_d = count_q + CW'(1);
            end
            res_d.score_out = fresh.score;
            res_d.kind_out  = fresh.kind;
            res_d.move_out  = fresh.move;
            res_d.age_out   = fresh.age;
            res_d.depth_out = fresh.depth;
          end else begin
            res_d.score_out = cur.score;
            res_d.kind_out  = cur.kind;
            res_d.move_out  = cur.move;
            res_d.age_out   = cur.age;
            res_d.depth_out = cur.depth;
          end
          state_d = ST_DONE;
        end else if (k_q == KW'(PROBE_LIMIT)) begin
          res_d        = '0;
          res_d.status = STAT_BOUND;
          state_d      = ST_DONE;
        end else begin
          idx_d   = mod_add(idx_q, sq_q);
          sq_d    = mod_add(sq_q, dd_q);
          dd_d    = mod_add(dd_q, IW'(2));
          k_d     = k_q + KW'(1);
          state_d = ST_READ;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      fill_q      <= FILL_RESET;
      count_q     <= '0;
      clr_q       <= '0;
      clr_resp_q  <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        fill_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      clr_q       <= clr_d;
      clr_resp_q  <= clr_resp_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
    out_q <= out_d;
    idx_q <= idx_d;
    sq_q  <= sq_d;
    dd_q  <= dd_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `HQPR_ASSERT(a_count_bound, count_q <= CW'(TABLE_ENTRIES), "entry count above table size")
  `HQPR_ASSERT(a_we_state, !ram_we || state_q == ST_CLEAR || state_q == ST_CHECK,
               "RAM write outside clear or check")
  `HQPR_ASSERT(a_done_hash, !mod_done || state_q == ST_HASH, "home slot ready out of turn")
  `HQPR_ASSERT(a_probe_bound, state_q != ST_CHECK || (k_q >= KW'(1) && k_q <= KW'(PROBE_LIMIT)),
               "probe number out of range")
  `HQPR_ASSERT_NEXT(a_written_ok, state_q == ST_CHECK && ram_we,
                    res_q.written && res_q.status == STAT_OK && state_q == ST_DONE,
                    "write without written flag")

endmodule

`default_nettype wire
